[hw/rtl/prarb_pkg.sv]
// Shared types and codes for the power rail override arbiter.
package prarb_pkg;

  localparam int unsigned NumRails = 3;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_OVERRIDE = 2'd1,
    OP_ESTOP    = 2'd2
  } opcode_t;

  // The opcode value that names no operation.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    MODE_FOLLOW = 2'd0,
    MODE_ON     = 2'd1,
    MODE_OFF    = 2'd2
  } mode_t;

  // Register indexes, taken from paddr[2].
  localparam logic REG_SWITCH_POL = 1'b0;
  localparam logic REG_POWER_POL  = 1'b1;

  // The override channel that addresses no rail.
  localparam logic [1:0] CHANNEL_NONE = 2'd3;

  typedef struct packed {
    mode_t [NumRails-1:0] mode;
    logic                 latch;
    logic [NumRails-1:0]  prev_sw;
    logic                 have_sample;
    logic [NumRails-1:0]  rail;
  } arb_state_t;

  typedef struct packed {
    logic [NumRails-1:0] rail_power;
    logic [3:0]          pin_levels;
    logic                pins_written;
    logic                rail1_toggled;
    logic                emergency_latched;
  } arb_result_t;

  typedef struct packed {
    logic sw_closed_high;
    logic rail_on_high;
  } arb_cfg_t;

endpackage

[hw/rtl/prarb_core.sv]
// Next-state and result logic for one word of the rail arbiter.
module prarb_core (
  input  prarb_pkg::arb_state_t  state_i,
  input  prarb_pkg::arb_cfg_t    cfg_i,
  input  logic [1:0]             opcode_i,
  input  logic [2:0]             switch_levels_i,
  input  logic [1:0]             channel_i,
  input  logic                   enable_i,
  input  logic [2:0]             stop_targets_i,
  output prarb_pkg::arb_state_t  state_o,
  output prarb_pkg::arb_result_t result_o
);

  logic                  do_refresh;
  prarb_pkg::arb_state_t pre;
  prarb_pkg::arb_state_t nxt;
  logic [2:0]            closed;
  logic [2:0]            edges;
  logic [2:0]            on;
  logic [2:0]            changed;

  always_comb begin
    pre        = state_i;
    do_refresh = 1'b0;
    case (opcode_i)
      prarb_pkg::OP_SAMPLE: begin
        do_refresh = 1'b1;
      end
      prarb_pkg::OP_OVERRIDE: begin
        if (channel_i != prarb_pkg::CHANNEL_NONE) begin
          do_refresh = 1'b1;
          if (channel_i == 2'd0 && enable_i) begin
            pre.latch = 1'b0;
          end
          pre.mode[channel_i] = enable_i ? prarb_pkg::MODE_ON : prarb_pkg::MODE_OFF;
        end
      end
      prarb_pkg::OP_ESTOP: begin
        if (stop_targets_i != 3'd0) begin
          do_refresh = 1'b1;
          if (stop_targets_i[0]) begin
            pre.latch   = 1'b1;
            pre.mode[0] = prarb_pkg::MODE_FOLLOW;
          end
          if (stop_targets_i[1]) begin
            pre.mode[1] = prarb_pkg::MODE_OFF;
          end
          if (stop_targets_i[2]) begin
            pre.mode[2] = prarb_pkg::MODE_OFF;
          end
        end
      end
      default: begin
        do_refresh = 1'b0;
      end
    endcase
  end

  assign closed = cfg_i.sw_closed_high ? switch_levels_i : ~switch_levels_i;
  assign edges  = state_i.have_sample ? (closed ^ state_i.prev_sw) : 3'd0;

  always_comb begin
    nxt = pre;
    // A switch edge hands the rail back to its switch.
    for (int i = 0; i < prarb_pkg::NumRails; i++) begin
      if (edges[i]) begin
        nxt.mode[i] = prarb_pkg::MODE_FOLLOW;
      end
    end
    if (edges[0]) begin
      nxt.latch = 1'b0;
    end
    for (int i = 0; i < prarb_pkg::NumRails; i++) begin
      case (nxt.mode[i])
        prarb_pkg::MODE_ON:  on[i] = 1'b1;
        prarb_pkg::MODE_OFF: on[i] = 1'b0;
        default:             on[i] = closed[i];
      endcase
    end
    if (nxt.latch) begin
      on[0] = 1'b0;
    end
    nxt.prev_sw     = closed;
    nxt.have_sample = 1'b1;
    nxt.rail        = on;
  end

  assign state_o = do_refresh ? nxt : state_i;
  assign changed = do_refresh ? (nxt.rail ^ state_i.rail) : 3'd0;

  always_comb begin
    result_o.rail_power        = state_o.rail;
    result_o.pin_levels[0]     = state_o.rail[0] == cfg_i.rail_on_high;
    result_o.pin_levels[1]     = state_o.rail[1] == cfg_i.rail_on_high;
    result_o.pin_levels[2]     = state_o.rail[1] == cfg_i.rail_on_high;
    result_o.pin_levels[3]     = state_o.rail[2] == cfg_i.rail_on_high;
    result_o.pins_written      = |changed;
    result_o.rail1_toggled     = changed[0];
    result_o.emergency_latched = state_o.latch;
  end

endmodule

[hw/rtl/power_rail_override_arbiter.sv]
// An accepted word is held in the input register until it can advance; its result is then
// loaded into the result register, from which it is shown at the output.
// Throughput: one word per cycle while out_stall is low; the input register feeds one
// pass of rail logic that updates the state and loads the result register in the same cycle.
// Reset (rst_n low, synchronous) empties both stages, sets all rails to follow their
// switches with the latch clear and all rails off, and restores register defaults.
module power_rail_override_arbiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_switch_levels,
  input  logic [1:0]  in_channel,
  input  logic        in_enable,
  input  logic [2:0]  in_stop_targets,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_rail_power,
  output logic [3:0]  out_pin_levels,
  output logic        out_pins_written,
  output logic        out_rail1_toggled,
  output logic        out_emergency_latched,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                  s1_valid_r;
  logic [1:0]            s1_opcode_r;
  logic [2:0]            s1_switch_r;
  logic [1:0]            s1_channel_r;
  logic                  s1_enable_r;
  logic [2:0]            s1_targets_r;
  logic                  out_valid_r;
  prarb_pkg::arb_result_t out_r;
  prarb_pkg::arb_result_t res_nxt;
  prarb_pkg::arb_state_t  state_r;
  prarb_pkg::arb_state_t  state_nxt;
  prarb_pkg::arb_cfg_t    cfg_r;
  logic                  advance;
  logic                  in_take;
  logic                  cfg_write;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  prarb_core u_core (
    .state_i         (state_r),
    .cfg_i           (cfg_r),
    .opcode_i        (s1_opcode_r),
    .switch_levels_i (s1_switch_r),
    .channel_i       (s1_channel_r),
    .enable_i        (s1_enable_r),
    .stop_targets_i  (s1_targets_r),
    .state_o         (state_nxt),
    .result_o        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_opcode_r  <= in_opcode;
      s1_switch_r  <= in_switch_levels;
      s1_channel_r <= in_channel;
      s1_enable_r  <= in_enable;
      s1_targets_r <= in_stop_targets;
    end
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode        <= '{prarb_pkg::MODE_FOLLOW, prarb_pkg::MODE_FOLLOW,
                               prarb_pkg::MODE_FOLLOW};
      state_r.latch       <= 1'b0;
      state_r.prev_sw     <= 3'd0;
      state_r.have_sample <= 1'b0;
      state_r.rail        <= 3'd0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Low address bits are ignored, so each register also answers its byte aliases.
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sw_closed_high <= 1'b0;
      cfg_r.rail_on_high   <= 1'b1;
    end else if (cfg_write) begin
      if (paddr[2] == prarb_pkg::REG_SWITCH_POL) begin
        cfg_r.sw_closed_high <= pwdata[0];
      end else begin
        cfg_r.rail_on_high <= pwdata[0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == prarb_pkg::REG_POWER_POL) ?
                  {31'd0, cfg_r.rail_on_high} :
                  {31'd0, cfg_r.sw_closed_high};

  assign out_valid             = out_valid_r;
  assign out_rail_power        = out_r.rail_power;
  assign out_pin_levels        = out_r.pin_levels;
  assign out_pins_written      = out_r.pins_written;
  assign out_rail1_toggled     = out_r.rail1_toggled;
  assign out_emergency_latched = out_r.emergency_latched;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the power rail override arbiter.
module tb_top;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] sw;
    logic [1:0] channel;
    logic       enable;
    logic [2:0] targets;
  } rail_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [2:0]  in_switch_levels;
  logic [1:0]  in_channel;
  logic        in_enable;
  logic [2:0]  in_stop_targets;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_rail_power;
  logic [3:0]  out_pin_levels;
  logic        out_pins_written;
  logic        out_rail1_toggled;
  logic        out_emergency_latched;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  power_rail_override_arbiter dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_opcode             (in_opcode),
    .in_switch_levels      (in_switch_levels),
    .in_channel            (in_channel),
    .in_enable             (in_enable),
    .in_stop_targets       (in_stop_targets),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_rail_power        (out_rail_power),
    .out_pin_levels        (out_pin_levels),
    .out_pins_written      (out_pins_written),
    .out_rail1_toggled     (out_rail1_toggled),
    .out_emergency_latched (out_emergency_latched),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // Predicted arbiter state and register copies.
  prarb_pkg::mode_t       mode_q [prarb_pkg::NumRails] =
      '{prarb_pkg::MODE_FOLLOW, prarb_pkg::MODE_FOLLOW, prarb_pkg::MODE_FOLLOW};
  logic                   latch_q = 1'b0;
  logic [2:0]             prev_sw_q = '0;
  logic                   have_sample_q = 1'b0;
  logic [2:0]             rail_q = '0;
  prarb_pkg::arb_cfg_t    cfg_q = '{sw_closed_high: 1'b0, rail_on_high: 1'b1};

  prarb_pkg::arb_result_t rail_expect_q[$];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic [2:0]  last_sw = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Refreshes the predicted rails from raw switch levels and returns the changed mask.
  function automatic logic [2:0] refresh_rails(input logic [2:0] raw);
    logic [2:0] closed;
    logic [2:0] edges;
    logic [2:0] next;
    closed = cfg_q.sw_closed_high ? raw : ~raw;
    edges  = have_sample_q ? (closed ^ prev_sw_q) : 3'b000;
    next   = '0;
    for (int i = 0; i < prarb_pkg::NumRails; i++) begin
      if (edges[i]) begin
        mode_q[i] = prarb_pkg::MODE_FOLLOW;
        if (i == 0) latch_q = 1'b0;
      end
    end
    for (int i = 0; i < prarb_pkg::NumRails; i++) begin
      if (i == 0 && latch_q) begin
        next[i] = 1'b0;
      end else begin
        case (mode_q[i])
          prarb_pkg::MODE_OFF: next[i] = 1'b0;
          prarb_pkg::MODE_ON:  next[i] = 1'b1;
          default:             next[i] = closed[i];
        endcase
      end
    end
    prev_sw_q     = closed;
    have_sample_q = 1'b1;
    refresh_rails = next ^ rail_q;
    rail_q        = next;
  endfunction

  task automatic predict_rails(input rail_cmd_t c);
    logic [2:0]             changed;
    logic                   p1, p2, p3;
    prarb_pkg::arb_result_t r;
    changed = '0;
    case (c.opcode)
      prarb_pkg::OP_SAMPLE: changed = refresh_rails(c.sw);
      prarb_pkg::OP_OVERRIDE: begin
        if (c.channel != prarb_pkg::CHANNEL_NONE) begin
          if (c.channel == 2'd0 && c.enable) latch_q = 1'b0;
          mode_q[c.channel] = c.enable ? prarb_pkg::MODE_ON : prarb_pkg::MODE_OFF;
          changed = refresh_rails(c.sw);
        end
      end
      prarb_pkg::OP_ESTOP: begin
        if (c.targets != 3'b000) begin
          if (c.targets[0]) begin
            latch_q   = 1'b1;
            mode_q[0] = prarb_pkg::MODE_FOLLOW;
          end
          if (c.targets[1]) mode_q[1] = prarb_pkg::MODE_OFF;
          if (c.targets[2]) mode_q[2] = prarb_pkg::MODE_OFF;
          changed = refresh_rails(c.sw);
        end
      end
      default: ;
    endcase
    p1 = (rail_q[0] == cfg_q.rail_on_high);
    p2 = (rail_q[1] == cfg_q.rail_on_high);
    p3 = (rail_q[2] == cfg_q.rail_on_high);
    r.rail_power        = rail_q;
    r.pin_levels        = {p3, p2, p2, p1};
    r.pins_written      = |changed;
    r.rail1_toggled     = changed[0];
    r.emergency_latched = latch_q;
    rail_expect_q.push_back(r);
  endtask

  function automatic rail_cmd_t cmd(input logic [1:0] op, input logic [2:0] sw,
                                    input logic [1:0] ch, input logic en,
                                    input logic [2:0] tg);
    cmd = '{opcode: op, sw: sw, channel: ch, enable: en, targets: tg};
  endfunction

  // Switch levels mostly hold still so that forced modes survive for a while.
  function automatic rail_cmd_t random_cmd();
    rail_cmd_t  c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45)      c.opcode = prarb_pkg::OP_SAMPLE;
    else if (pick < 75) c.opcode = prarb_pkg::OP_OVERRIDE;
    else if (pick < 95) c.opcode = prarb_pkg::OP_ESTOP;
    else                c.opcode = prarb_pkg::OP_UNUSED;
    pick = $urandom_range(99);
    if (pick < 70)      c.sw = last_sw;
    else if (pick < 90) c.sw = last_sw ^ (3'b001 << $urandom_range(2));
    else                c.sw = 3'($urandom_range(7));
    last_sw   = c.sw;
    c.channel = ($urandom_range(9) == 0) ? prarb_pkg::CHANNEL_NONE : 2'($urandom_range(2));
    c.enable  = 1'($urandom_range(1));
    c.targets = ($urandom_range(9) == 0) ? 3'b000 : 3'($urandom_range(7, 1));
    return c;
  endfunction

  task automatic send_word(input rail_cmd_t c);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= c.opcode;
    in_switch_levels <= c.sw;
    in_channel       <= c.channel;
    in_enable        <= c.enable;
    in_stop_targets  <= c.targets;
    do @(posedge clk); while (in_stall);
    predict_rails(c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rail_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == prarb_pkg::REG_SWITCH_POL) cfg_q.sw_closed_high = val;
    else                                  cfg_q.rail_on_high   = val;
  endtask

  task automatic set_polarity(input logic sw_high, input logic pwr_high);
    drain();
    write_reg(prarb_pkg::REG_SWITCH_POL, sw_high);
    write_reg(prarb_pkg::REG_POWER_POL, pwr_high);
  endtask

  // Walks the first-sample rule, every operation, ignored words, and latch set and clear.
  task automatic test_directed();
    rail_cmd_t seq[$];
    seq = '{
      cmd(prarb_pkg::OP_SAMPLE,   3'b111, 2'd0, 1'b0, 3'b000),
      cmd(prarb_pkg::OP_SAMPLE,   3'b000, 2'd3, 1'b1, 3'b111),
      cmd(prarb_pkg::OP_OVERRIDE, 3'b000, 2'd0, 1'b0, 3'b000),
      cmd(prarb_pkg::OP_OVERRIDE, 3'b000, 2'd1, 1'b0, 3'b000),
      cmd(prarb_pkg::OP_OVERRIDE, 3'b000, 2'd2, 1'b1, 3'b000),
      cmd(prarb_pkg::OP_OVERRIDE, 3'b111, prarb_pkg::CHANNEL_NONE, 1'b1, 3'b111),
      cmd(prarb_pkg::OP_ESTOP,    3'b111, 2'd3, 1'b1, 3'b000),
      cmd(prarb_pkg::OP_UNUSED,   3'b101, 2'd0, 1'b1, 3'b111),
      cmd(prarb_pkg::OP_OVERRIDE, 3'b000, 2'd0, 1'b1, 3'b000),
      cmd(prarb_pkg::OP_ESTOP,    3'b000, 2'd0, 1'b0, 3'b001),
      cmd(prarb_pkg::OP_SAMPLE,   3'b000, 2'd0, 1'b0, 3'b000),
      cmd(prarb_pkg::OP_OVERRIDE, 3'b000, 2'd0, 1'b1, 3'b000),
      cmd(prarb_pkg::OP_ESTOP,    3'b000, 2'd2, 1'b1, 3'b111),
      cmd(prarb_pkg::OP_SAMPLE,   3'b001, 2'd0, 1'b0, 3'b000),
      cmd(prarb_pkg::OP_SAMPLE,   3'b111, 2'd0, 1'b0, 3'b000),
      cmd(prarb_pkg::OP_ESTOP,    3'b111, 2'd0, 1'b0, 3'b110),
      cmd(prarb_pkg::OP_OVERRIDE, 3'b111, 2'd2, 1'b1, 3'b000),
      cmd(prarb_pkg::OP_SAMPLE,   3'b000, 2'd1, 1'b1, 3'b010),
      cmd(prarb_pkg::OP_ESTOP,    3'b010, 2'd0, 1'b0, 3'b001),
      cmd(prarb_pkg::OP_SAMPLE,   3'b011, 2'd0, 1'b0, 3'b000)
    };
    foreach (seq[i]) send_word(seq[i]);
    last_sw = seq[seq.size() - 1].sw;
  endtask

  task automatic test_random(input int unsigned n);
    repeat (n) send_word(random_cmd());
  endtask

  // The sender holds off mid-stream until every result is back, then resumes.
  task automatic test_drain_pause(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 50 == 25) drain();
      send_word(random_cmd());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else        out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    prarb_pkg::arb_result_t exp_r;
    prarb_pkg::arb_result_t got_r;
    if (rst_n && out_valid && !out_stall) begin
      got_r = '{rail_power: out_rail_power, pin_levels: out_pin_levels,
                pins_written: out_pins_written, rail1_toggled: out_rail1_toggled,
                emergency_latched: out_emergency_latched};
      if (rail_expect_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result word: %p", got_r);
      end else begin
        exp_r = rail_expect_q.pop_front();
        if (got_r.rail_power !== exp_r.rail_power ||
            got_r.pin_levels !== exp_r.pin_levels ||
            got_r.pins_written !== exp_r.pins_written ||
            got_r.rail1_toggled !== exp_r.rail1_toggled ||
            got_r.emergency_latched !== exp_r.emergency_latched) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("result mismatch: expected %p actual %p", exp_r, got_r);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("power_rail_override_arbiter regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_opcode        <= prarb_pkg::OP_SAMPLE;
    in_switch_levels <= '0;
    in_channel       <= '0;
    in_enable        <= 1'b0;
    in_stop_targets  <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_gap_pct   = 16;
    rx_stall_pct = 73;
    test_directed();
    set_polarity(1'b1, 1'b1);
    test_random(250);
    set_polarity(1'b1, 1'b0);
    test_random(250);

    tx_gap_pct   = 73;
    rx_stall_pct = 16;
    set_polarity(1'b0, 1'b0);
    test_random(250);
    set_polarity(1'b0, 1'b1);
    test_drain_pause(250);

    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    set_polarity(1'b1, 1'b0);
    test_random(250);
    set_polarity(1'b0, 1'b1);
    test_random(250);

    drain();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) $display("power_rail_override_arbiter regression: pass");
    else               $display("power_rail_override_arbiter regression: fail");
    $finish;
  end

endmodule
